FILE: src/plpce_pkg.sv
`timescale 1ns / 1ps

package plpce_pkg;

    localparam int ROW_STEP       = 19;
    localparam int COL_STEP       = 26;
    localparam int DIAG_STEP      = 11;
    localparam int AMPLITUDE      = 255;
    localparam int SUM_BIAS       = 765;
    localparam int LEVEL_MAX      = 255;
    localparam int DIV6_MUL       = 10923;
    localparam int DIV6_SHIFT     = 16;
    localparam int ALPHA_RESET    = 100;
    localparam int PAL_DEPTH      = 256;
    localparam int PAL_AW         = 8;
    localparam int COLOR_W        = 24;
    localparam int ALPHA_W        = 8;
    localparam int LEVEL_W        = 8;
    localparam int SAMPLE_W       = 9;
    localparam int BSUM_W         = 11;
    localparam int MUL_W          = 25;
    localparam int IDX_SUM_W      = 13;
    localparam int OUT_FIFO_DEPTH = 8;
    localparam int FIFO_AW        = $clog2(OUT_FIFO_DEPTH);
    localparam int FIFO_CW        = $clog2(OUT_FIFO_DEPTH + 1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [FIFO_CW-1:0]         fifo_count_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]           level;
        logic [ALPHA_W+COLOR_W-1:0]   color_argb;
    } out_item_t;

    // step is the angle of one table entry, 2*pi/depth
    function automatic sample_t sine_value(input int depth, input int idx, input real step);
        real     ang;
        real     v;
        int      mag;
        sample_t res;
        ang = step * real'(idx);
        if (idx == 0 || 2 * idx == depth)
        begin
            res = '0;
        end
        else if (4 * idx == depth)
        begin
            res = SAMPLE_W'(AMPLITUDE);
        end
        else if (4 * idx == 3 * depth)
        begin
            res = SAMPLE_W'(-AMPLITUDE);
        end
        else
        begin
            v = real'(AMPLITUDE) * $sin(ang);
            if (v < 0.0)
            begin
                mag = -int'($floor(-v));
            end
            else
            begin
                mag = int'($floor(v));
            end
            res = SAMPLE_W'(mag);
        end
        return res;
    endfunction

endpackage

FILE: src/plpce_sine_rom.sv
`timescale 1ns / 1ps

module plpce_sine_rom
    import plpce_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output sample_t                  data
);

    localparam real ANG_STEP = 2.0 * 3.14159265358979323846 / real'(DEPTH);

    sample_t rom_mem [DEPTH];
    sample_t data_reg;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_rom
        assign rom_mem[g] = sine_value(DEPTH, g, ANG_STEP);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_mem[addr];
    end

    assign data = data_reg;

endmodule

FILE: src/plpce_out_fifo.sv
`timescale 1ns / 1ps

module plpce_out_fifo
    import plpce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  out_item_t   push_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output out_item_t   head_data,
    output fifo_count_t count
);

    out_item_t           fifo_mem [OUT_FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    fifo_count_t         count_reg;
    logic [FIFO_AW-1:0]  wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_next;
    fifo_count_t         count_next;
    logic                pop;

    assign pop = (count_reg != '0) && m_tready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign m_tvalid  = (count_reg != '0);
    assign head_data = fifo_mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

FILE: src/plasma_palette_color_engine_core.sv
`timescale 1ns / 1ps

// Plasma color engine: each cell transaction (tuser = 0) sums three sine samples
// taken at row*19+phase_row, col*26+phase_col and (row+col)*11+phase_diag mod
// SINE_DEPTH (a power of two), scales the sum to an 8-bit level and looks that
// level up in a 256-entry palette RAM, giving ARGB with the alpha register on top.
// A palette transaction (tuser = 1) writes one RAM entry and yields no output;
// it affects every cell accepted after it. One transaction is taken per clock while
// s_tready is high: three synchronous sine ROM reads, the sum, a divide by 6
// through the reciprocal multiply and the synchronous palette read form a
// four-stage pipeline ahead of the output FIFO; the last stage pushes into the FIFO,
// whose registered count drives m_tvalid. Results wait in an 8-entry output FIFO;
// s_tready drops only when FIFO plus pipeline hold eight transactions.
// Palette entries read before they are written return undefined colors.
module plasma_palette_color_engine_core
    import plpce_pkg::*;
#(
    parameter int SINE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row[5:0], col[11:6], phase_row[21:12], phase_col[31:22], phase_diag[41:32],
    // pal_index[49:42], pal_color[73:50], zero fill [79:74]
    input  logic [79:0] s_tdata,
    // func[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // color_argb[31:0], level[39:32]
    output logic [39:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int SINE_AW = $clog2(SINE_DEPTH);

    logic [5:0]          row;
    logic [5:0]          col;
    logic [9:0]          phase_row;
    logic [9:0]          phase_col;
    logic [9:0]          phase_diag;
    logic [PAL_AW-1:0]   pal_index;
    logic [COLOR_W-1:0]  pal_color;
    logic                accept;

    logic [IDX_SUM_W-1:0] idx_row;
    logic [IDX_SUM_W-1:0] idx_col;
    logic [IDX_SUM_W-1:0] idx_diag;
    sample_t              smp_row;
    sample_t              smp_col;
    sample_t              smp_diag;

    logic [ALPHA_W-1:0]  alpha_reg;

    logic                p1_valid_reg;
    logic                p2_valid_reg;
    logic                p3_valid_reg;
    logic                p4_valid_reg;
    logic                p1_func_reg;
    logic                p2_func_reg;
    logic                p3_func_reg;
    logic                p4_func_reg;
    logic [PAL_AW-1:0]   p1_index_reg;
    logic [PAL_AW-1:0]   p2_index_reg;
    logic [PAL_AW-1:0]   p3_index_reg;
    logic [COLOR_W-1:0]  p1_color_reg;
    logic [COLOR_W-1:0]  p2_color_reg;
    logic [COLOR_W-1:0]  p3_color_reg;
    logic [BSUM_W-1:0]   p2_bsum_reg;
    logic [LEVEL_W-1:0]  p3_level_reg;
    logic [LEVEL_W-1:0]  p4_level_reg;
    logic [COLOR_W-1:0]  p4_rgb_reg;

    logic signed [BSUM_W:0] ssum;
    logic [BSUM_W-1:0]      bsum_next;
    logic [MUL_W-1:0]       prod;
    logic [LEVEL_W:0]       level_raw;
    logic [LEVEL_W-1:0]     level_next;

    logic [COLOR_W-1:0]  pal_mem [PAL_DEPTH];

    out_item_t           push_data;
    out_item_t           head_data;
    logic                push;
    fifo_count_t         fifo_count;
    logic [FIFO_CW:0]    occupancy;

    assign row        = s_tdata[5:0];
    assign col        = s_tdata[11:6];
    assign phase_row  = s_tdata[21:12];
    assign phase_col  = s_tdata[31:22];
    assign phase_diag = s_tdata[41:32];
    assign pal_index  = s_tdata[49:42];
    assign pal_color  = s_tdata[73:50];

    // reserve a FIFO slot for every transaction in flight
    assign occupancy = (FIFO_CW + 1)'(fifo_count)
                     + (FIFO_CW + 1)'(p1_valid_reg) + (FIFO_CW + 1)'(p2_valid_reg)
                     + (FIFO_CW + 1)'(p3_valid_reg) + (FIFO_CW + 1)'(p4_valid_reg);
    assign s_tready  = (occupancy < (FIFO_CW + 1)'(OUT_FIFO_DEPTH));
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign idx_row  = IDX_SUM_W'(row) * IDX_SUM_W'(ROW_STEP) + IDX_SUM_W'(phase_row);
    assign idx_col  = IDX_SUM_W'(col) * IDX_SUM_W'(COL_STEP) + IDX_SUM_W'(phase_col);
    assign idx_diag = (IDX_SUM_W'(row) + IDX_SUM_W'(col)) * IDX_SUM_W'(DIAG_STEP)
                    + IDX_SUM_W'(phase_diag);

    plpce_sine_rom #(.DEPTH(SINE_DEPTH)) u_rom_row
    (
        .clk  (clk),
        .addr (idx_row[SINE_AW-1:0]),
        .data (smp_row)
    );

    plpce_sine_rom #(.DEPTH(SINE_DEPTH)) u_rom_col
    (
        .clk  (clk),
        .addr (idx_col[SINE_AW-1:0]),
        .data (smp_col)
    );

    plpce_sine_rom #(.DEPTH(SINE_DEPTH)) u_rom_diag
    (
        .clk  (clk),
        .addr (idx_diag[SINE_AW-1:0]),
        .data (smp_diag)
    );

    always_comb
    begin
        ssum      = (BSUM_W + 1)'(smp_row) + (BSUM_W + 1)'(smp_col)
                  + (BSUM_W + 1)'(smp_diag) + (BSUM_W + 1)'(SUM_BIAS);
        bsum_next = ssum[BSUM_W-1:0];
        // divide by 6 through the reciprocal
        prod      = MUL_W'(p2_bsum_reg) * MUL_W'(DIV6_MUL);
        level_raw = prod[DIV6_SHIFT +: LEVEL_W + 1];
        level_next = (level_raw > (LEVEL_W + 1)'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                              : level_raw[LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg    <= ALPHA_W'(ALPHA_RESET);
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                alpha_reg <= cfg_data;
            end
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_func_reg  <= s_tuser[0];
        p1_index_reg <= pal_index;
        p1_color_reg <= pal_color;
        p2_func_reg  <= p1_func_reg;
        p2_index_reg <= p1_index_reg;
        p2_color_reg <= p1_color_reg;
        p2_bsum_reg  <= bsum_next;
        p3_func_reg  <= p2_func_reg;
        p3_index_reg <= p2_index_reg;
        p3_color_reg <= p2_color_reg;
        p3_level_reg <= level_next;
        p4_func_reg  <= p3_func_reg;
        p4_level_reg <= p3_level_reg;
    end

    // all palette accesses happen in one stage, so order needs no forwarding
    always_ff @(posedge clk)
    begin
        if (p3_valid_reg && p3_func_reg)
        begin
            pal_mem[p3_index_reg] <= p3_color_reg;
        end
        p4_rgb_reg <= pal_mem[p3_level_reg];
    end

    assign push                 = p4_valid_reg && !p4_func_reg;
    assign push_data.level      = p4_level_reg;
    assign push_data.color_argb = {alpha_reg, p4_rgb_reg};

    plpce_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .head_data (head_data),
        .count     (fifo_count)
    );

    assign m_tdata = head_data;

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (FIFO_CW + 1)'(OUT_FIFO_DEPTH))
        else $error("output FIFO credit exceeded");

    a_cell_reaches_ram: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser[0]) |-> ##3 (p3_valid_reg && !p3_func_reg))
        else $error("cell transaction lost in pipeline");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (p4_valid_reg && p4_func_reg) |=> (fifo_count <= $past(fifo_count)))
        else $error("palette write produced a result");

endmodule
